>>> sv/tplc_pkg.sv
// Shared types and constants of the padded layout calculator.
`timescale 1ns / 1ps
package tplc_pkg;

  localparam int NUM_ALIGN = 6;
  localparam int DIM_W     = 32;
  localparam int WIDE_W    = 64;
  localparam int POS_W     = 4;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NODED = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_RANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_POS5 = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic             last;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef struct packed {
    logic [2:0]                        rank;
    logic [NUM_ALIGN-1:0][DIM_W-1:0]   align;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
  } op_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] quo;
    logic [WIDE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] prod;
    logic              ovf;
  } mul_rsp_t;

endpackage

>>> sv/tplc_ifs.sv
// Channel interfaces: dimension words in, layout result words out.
`timescale 1ns / 1ps
interface tplc_dim_if;
  logic        valid;
  logic        ready;
  logic [31:0] dim_size;
  logic        outermost;
  modport source(output valid, dim_size, outermost, input ready);
  modport sink(input valid, dim_size, outermost, output ready);
endinterface

interface tplc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  position;
  logic [31:0] padded_size;
  logic [63:0] stride_elems;
  logic [63:0] phys_height;
  logic [63:0] phys_width;
  logic [1:0]  status;
  logic        final_result;
  modport source(output valid, position, padded_size, stride_elems, phys_height,
                 phys_width, status, final_result, input ready);
  modport sink(input valid, position, padded_size, stride_elems, phys_height,
               phys_width, status, final_result, output ready);
endinterface

>>> sv/tensor_padded_layout_calc.sv
// Top level of the padded layout calculator: config registers and unit wiring.
//
// Usage: send a tensor shape on the dims channel one dimension word at a time,
// innermost first, with outermost set on the last one (a shape also ends at
// position DIM_LIMIT-1). Each word yields one result word on the results channel
// with its padded size and stride; the last word of a shape also yields filler
// positions up to the alignment rank, and its final result carries the
// flattened physical height and width. Both channels are valid/ready.
// Alignment registers are written through cfg_we/cfg_index/cfg_data, by the user
// only while idle; the block itself does not enforce this. Each dimension runs
// through a sequencer that shares one iterative 64-bit divider and one
// iterative 64-bit multiplier. An unaligned innermost dimension needs one
// product, an unaligned outer one three products, and an outer aligned position
// up to five divisions and three products.
// A two-word queue decouples input acceptance from the arithmetic, and an
// output register holds a result while the receiver stalls; the sequencer then
// waits and the queue fills before dims.ready drops.
// Reset clears the running state, queue and output valid, sets align_rank to 0
// and every alignment to 1.
`timescale 1ns / 1ps
module tensor_padded_layout_calc #(
  parameter int MAX_ALIGN_RANK = 6,
  parameter int DIM_LIMIT      = 8
) (
  input  logic        clk,
  input  logic        rst,
  tplc_dim_if.sink    dims,
  tplc_res_if.source  results,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  tplc_pkg::cfg_t     cfg;
  logic               q_valid;
  logic               q_pop;
  tplc_pkg::item_t    q_item;
  tplc_pkg::op_req_t  div_req;
  tplc_pkg::div_rsp_t div_rsp;
  tplc_pkg::op_req_t  mul_req;
  tplc_pkg::mul_rsp_t mul_rsp;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rank <= 3'd0;
      for (int i = 0; i < tplc_pkg::NUM_ALIGN; i++) begin
        cfg.align[i] <= 32'd1;
      end
    end else if (cfg_we) begin
      if (cfg_index == tplc_pkg::CFG_ALIGN_RANK) begin
        cfg.rank <= cfg_data[2:0];
      end
      for (int i = 0; i < tplc_pkg::NUM_ALIGN; i++) begin
        if (cfg_index == tplc_pkg::CFG_ALIGN_POS0 + 3'(i)) begin
          cfg.align[i] <= cfg_data;
        end
      end
    end
  end

  tplc_front #(.DIM_LIMIT(DIM_LIMIT)) u_front (
    .clk(clk), .rst(rst), .dims(dims),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  tplc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  tplc_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));

  tplc_back #(.MAX_ALIGN_RANK(MAX_ALIGN_RANK)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .div_req(div_req), .div_rsp(div_rsp),
    .mul_req(mul_req), .mul_rsp(mul_rsp),
    .results(results)
  );

  // Status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.status != 2'd3))
    else $error("result status holds an undefined code");

  // Flattened sizes appear only on the final word
  a_phys_final: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.final_result) |->
      (results.phys_height == 64'd0 && results.phys_width == 64'd0))
    else $error("flattened size on a non-final result");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

  // Divider and multiplier are never started together
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    !(div_req.start && mul_req.start))
    else $error("divider and multiplier started in the same cycle");
endmodule

>>> sv/tplc_div.sv
// Iterative 64-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tplc_div (
  input  logic              clk,
  input  logic              rst,
  input  tplc_pkg::op_req_t req,
  output tplc_pkg::div_rsp_t rsp
);
  logic [tplc_pkg::WIDE_W-1:0] rem;
  logic [tplc_pkg::WIDE_W-1:0] quo;
  logic [tplc_pkg::WIDE_W-1:0] dvs;
  logic [5:0]                  cnt;
  logic                        busy;
  logic                        done;
  logic [tplc_pkg::WIDE_W:0]   shifted;
  logic [tplc_pkg::WIDE_W:0]   diff;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem, quo[tplc_pkg::WIDE_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.a;
        dvs  <= req.b;
      end else if (busy) begin
        if (!diff[tplc_pkg::WIDE_W]) begin
          rem <= diff[tplc_pkg::WIDE_W-1:0];
          quo <= {quo[tplc_pkg::WIDE_W-2:0], 1'b1};
        end else begin
          rem <= shifted[tplc_pkg::WIDE_W-1:0];
          quo <= {quo[tplc_pkg::WIDE_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;
endmodule

>>> sv/tplc_mul.sv
// Iterative 64x64 shift-add multiplier with overflow detect, one bit per cycle.
`timescale 1ns / 1ps
module tplc_mul (
  input  logic              clk,
  input  logic              rst,
  input  tplc_pkg::op_req_t req,
  output tplc_pkg::mul_rsp_t rsp
);
  logic [tplc_pkg::WIDE_W-1:0] hi;
  logic [tplc_pkg::WIDE_W-1:0] lo;
  logic [tplc_pkg::WIDE_W-1:0] mcand;
  logic [5:0]                  cnt;
  logic                        busy;
  logic                        done;
  logic [tplc_pkg::WIDE_W:0]   sum;

  // Add the multiplicand when the low multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        hi    <= '0;
        lo    <= req.a;
        mcand <= req.b;
      end else if (busy) begin
        hi  <= sum[tplc_pkg::WIDE_W:1];
        lo  <= {sum[0], lo[tplc_pkg::WIDE_W-1:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = lo;
  assign rsp.ovf  = (hi != '0);
endmodule

>>> sv/tplc_front.sv
// Front end: accepts dimension words, tags position and shape end, queues them.
`timescale 1ns / 1ps
module tplc_front #(
  parameter int DIM_LIMIT = 8
) (
  input  logic                clk,
  input  logic                rst,
  tplc_dim_if.sink            dims,
  output logic                q_valid,
  input  logic                q_pop,
  output tplc_pkg::item_t     q_item
);
  tplc_pkg::item_t                 slots [2];
  logic                            wptr;
  logic                            rptr;
  logic [1:0]                      count;
  logic [tplc_pkg::POS_W-1:0]      pos;
  logic                            accept;
  logic                            is_last;

  assign dims.ready = (count != 2'd2);
  assign accept     = dims.valid && dims.ready;
  assign is_last    = dims.outermost || (pos >= tplc_pkg::POS_W'(DIM_LIMIT - 1));
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rptr];

  // Track position within the shape, wrap after the last dimension
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= is_last ? '0 : pos + 1'b1;
    end
  end

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (q_pop && q_valid) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, accept} - {1'b0, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wptr] <= '{dim: dims.dim_size, last: is_last, pos: pos};
    end
  end
endmodule

>>> sv/tplc_back.sv
// Back end: sequences padding, stride and flattened size arithmetic per position.
`timescale 1ns / 1ps
module tplc_back #(
  parameter int MAX_ALIGN_RANK = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tplc_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  tplc_pkg::item_t      q_item,
  output tplc_pkg::op_req_t    div_req,
  input  tplc_pkg::div_rsp_t   div_rsp,
  output tplc_pkg::op_req_t    mul_req,
  input  tplc_pkg::mul_rsp_t   mul_rsp,
  tplc_res_if.source           results
);
  typedef enum logic [4:0] {
    S_IDLE, S_PAD, S_PADW1, S_PADW2, S_PADCHK, S_ACCW, S_WID, S_WIDSET,
    S_HGT, S_HGTW, S_HGTSET, S_STR, S_STRW, S_STRSET, S_EMIT, S_RUP, S_RUPW
  } state_t;

  localparam logic [63:0] ALL64 = '1;

  state_t        state;
  state_t        ret;
  logic [3:0]    p;
  logic [31:0]   d;
  logic          last;
  logic          extra;
  logic [63:0]   rv;
  logic [63:0]   rm;
  logic [31:0]   pad;
  logic [63:0]   accum;
  logic [63:0]   rstride;
  logic [63:0]   pstride;
  logic [63:0]   rheight;
  logic [63:0]   rwidth;
  logic [1:0]    err;

  logic          o_valid;
  logic [3:0]    o_pos;
  logic [31:0]   o_pad;
  logic [63:0]   o_stride;
  logic [63:0]   o_ph;
  logic [63:0]   o_pw;
  logic [1:0]    o_status;
  logic          o_final;

  logic [2:0]    eff;
  logic          in_align;
  logic [31:0]   a_raw;
  logic [63:0]   a_eff;
  logic [64:0]   rup_sum;
  logic [63:0]   mul_sat;
  logic          more;
  logic          fin;

  // Effective alignment rank and alignment of the current position
  assign eff      = (cfg.rank > 3'(MAX_ALIGN_RANK)) ? 3'(MAX_ALIGN_RANK) : cfg.rank;
  assign in_align = (p < {1'b0, eff});

  always_comb begin
    a_raw = 32'd0;
    for (int i = 0; i < tplc_pkg::NUM_ALIGN; i++) begin
      if (p == 4'(i)) begin
        a_raw = cfg.align[i];
      end
    end
  end

  assign a_eff   = (in_align && a_raw != 32'd0) ? {32'd0, a_raw} : 64'd1;
  assign rup_sum = {1'b0, rv} + {1'b0, rm - div_rsp.rem};
  assign mul_sat = mul_rsp.ovf ? ALL64 : mul_rsp.prod;
  assign more    = ({1'b0, p} + 5'd1) < {2'd0, eff};
  assign fin     = last && !more;
  assign q_pop   = (state == S_IDLE) && q_valid;

  assign results.valid        = o_valid;
  assign results.position     = o_pos;
  assign results.padded_size  = o_pad;
  assign results.stride_elems = o_stride;
  assign results.phys_height  = o_ph;
  assign results.phys_width   = o_pw;
  assign results.status       = o_status;
  assign results.final_result = o_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      o_valid       <= 1'b0;
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      accum         <= 64'd1;
      rstride       <= 64'd1;
      rheight       <= 64'd1;
      rwidth        <= 64'd1;
      err           <= tplc_pkg::ST_OK;
    end else begin
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      // Drop the output word once taken, unless a new one replaces it
      if (o_valid && results.ready && state != S_EMIT) begin
        o_valid <= 1'b0;
      end
      case (state)
        // Take the next dimension word from the queue
        S_IDLE: begin
          if (q_valid) begin
            p       <= q_item.pos;
            d       <= q_item.dim;
            last    <= q_item.last;
            extra   <= 1'b0;
            pstride <= rstride;
            state   <= S_PAD;
          end
        end
        // Pick the padding rule for this position
        S_PAD: begin
          if (!in_align) begin
            rv    <= {32'd0, d};
            state <= S_PADCHK;
          end else if (p < 4'd2) begin
            rv    <= {32'd0, d};
            rm    <= a_eff;
            ret   <= S_PADCHK;
            state <= S_RUP;
          end else begin
            div_req.start <= 1'b1;
            div_req.a     <= accum;
            div_req.b     <= a_eff;
            state         <= S_PADW1;
          end
        end
        S_PADW1: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              rv    <= {32'd0, d};
              state <= S_PADCHK;
            end else if (accum == '0) begin
              if (err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_NODED;
              rv    <= {32'd0, d};
              state <= S_PADCHK;
            end else begin
              div_req.start <= 1'b1;
              div_req.a     <= a_eff;
              div_req.b     <= accum;
              state         <= S_PADW2;
            end
          end
        end
        S_PADW2: begin
          if (div_rsp.done) begin
            rv <= {32'd0, d};
            if (div_rsp.rem != '0) begin
              if (err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_NODED;
              state <= S_PADCHK;
            end else begin
              rm    <= div_rsp.quo;
              ret   <= S_PADCHK;
              state <= S_RUP;
            end
          end
        end
        // Saturate the padded size to 32 bits, fold it into the running alignment past position 0
        S_PADCHK: begin
          if (rv[63:32] != '0) begin
            if (err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_OVF;
            pad <= '1;
          end else begin
            pad <= rv[31:0];
          end
          if (p != 4'd0) begin
            mul_req.start <= 1'b1;
            mul_req.a     <= accum;
            mul_req.b     <= (rv[63:32] != '0) ? 64'hFFFF_FFFF : rv;
            state         <= S_ACCW;
          end else begin
            state <= S_WID;
          end
        end
        S_ACCW: begin
          if (mul_rsp.done) begin
            accum <= mul_sat;
            if (mul_rsp.ovf && err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_OVF;
            state <= S_HGT;
          end
        end
        // Innermost dimension sets the flattened width
        S_WID: begin
          rv    <= {32'd0, d};
          rm    <= a_eff;
          ret   <= S_WIDSET;
          state <= S_RUP;
        end
        S_WIDSET: begin
          rwidth <= rv;
          state  <= S_STR;
        end
        // Outer dimensions grow the flattened height
        S_HGT: begin
          mul_req.start <= 1'b1;
          mul_req.a     <= rheight;
          mul_req.b     <= {32'd0, d};
          state         <= S_HGTW;
        end
        S_HGTW: begin
          if (mul_rsp.done) begin
            if (mul_rsp.ovf && err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_OVF;
            rv    <= mul_sat;
            rm    <= a_eff;
            ret   <= S_HGTSET;
            state <= S_RUP;
          end
        end
        S_HGTSET: begin
          rheight <= rv;
          state   <= S_STR;
        end
        // Advance the running stride, except on filler positions
        S_STR: begin
          if (extra) begin
            state <= S_EMIT;
          end else begin
            mul_req.start <= 1'b1;
            mul_req.a     <= rstride;
            mul_req.b     <= {32'd0, d};
            state         <= S_STRW;
          end
        end
        S_STRW: begin
          if (mul_rsp.done) begin
            if (mul_rsp.ovf && err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_OVF;
            rv    <= mul_sat;
            rm    <= a_eff;
            ret   <= S_STRSET;
            state <= S_RUP;
          end
        end
        S_STRSET: begin
          rstride <= rv;
          state   <= S_EMIT;
        end
        // Hand the word to the output register; stride from before this position, 0 on fillers
        S_EMIT: begin
          if (!o_valid || results.ready) begin
            o_valid  <= 1'b1;
            o_pos    <= p;
            o_pad    <= pad;
            o_stride <= extra ? 64'd0 : pstride;
            o_status <= err;
            o_final  <= fin;
            o_ph     <= fin ? rheight : 64'd0;
            o_pw     <= fin ? rwidth : 64'd0;
            if (fin) begin
              accum   <= 64'd1;
              rstride <= 64'd1;
              rheight <= 64'd1;
              rwidth  <= 64'd1;
              err     <= tplc_pkg::ST_OK;
              state   <= S_IDLE;
            end else if (last) begin
              p     <= p + 4'd1;
              d     <= 32'd1;
              extra <= 1'b1;
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // Round rv up to a multiple of rm, saturating on overflow
        S_RUP: begin
          if (rm <= 64'd1) begin
            state <= ret;
          end else begin
            div_req.start <= 1'b1;
            div_req.a     <= rv;
            div_req.b     <= rm;
            state         <= S_RUPW;
          end
        end
        S_RUPW: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0) begin
              if (rup_sum[64]) begin
                if (err == tplc_pkg::ST_OK) err <= tplc_pkg::ST_OVF;
                rv <= ALL64;
              end else begin
                rv <= rup_sum[63:0];
              end
            end
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sim/tb.sv
// Self-checking bench for the padded layout calculator: random shapes, alignments and stalls.
`timescale 1ns / 1ps
module tb;

  localparam int DIM_LIMIT_TB = 8;
  localparam int NUM_ITEMS    = 420;
  localparam int WATCH_LIMIT  = 40000;
  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  position;
    logic [31:0] padded_size;
    logic [63:0] stride_elems;
    logic [63:0] phys_height;
    logic [63:0] phys_width;
    logic [1:0]  status;
    logic        final_result;
  } layout_t;

  // Layout predictor and store of pending layout words
  class layout_board;
    logic [2:0]  rank_reg;
    logic [31:0] align_reg [tplc_pkg::NUM_ALIGN];
    int unsigned pos_cnt;
    logic [63:0] acc, run_st, run_h, run_w;
    logic [1:0]  err;
    layout_t     pending [$];
    int          fails;

    function void clear_run();
      pos_cnt = 0; acc = 1; run_st = 1; run_h = 1; run_w = 1; err = tplc_pkg::ST_OK;
    endfunction

    function void reset_all();
      rank_reg = 0;
      foreach (align_reg[i]) align_reg[i] = 1;
      clear_run();
      pending.delete();
      fails = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx == tplc_pkg::CFG_ALIGN_RANK) rank_reg = val[2:0];
      else if (idx <= tplc_pkg::CFG_ALIGN_POS5) align_reg[idx - tplc_pkg::CFG_ALIGN_POS0] = val;
    endfunction

    function void raise(logic [1:0] code);
      if (err == tplc_pkg::ST_OK) err = code;
    endfunction

    function int unsigned eff_rank();
      return (rank_reg > tplc_pkg::NUM_ALIGN) ? tplc_pkg::NUM_ALIGN : rank_reg;
    endfunction

    function logic [63:0] align_at(int unsigned p);
      if (p >= eff_rank()) return 1;
      return (align_reg[p] == 0) ? 64'd1 : {32'd0, align_reg[p]};
    endfunction

    function logic [63:0] mul_chk(logic [63:0] a, logic [63:0] b);
      logic [127:0] full;
      full = a * b;
      if (full[127:64] != 0) begin
        raise(tplc_pkg::ST_OVF);
        return ALL64;
      end
      return full[63:0];
    endfunction

    function logic [63:0] pad_up(logic [63:0] v, logic [63:0] m);
      logic [63:0] r;
      logic [64:0] sum;
      if (m <= 1) return v;
      r = v % m;
      if (r == 0) return v;
      sum = {1'b0, v} + (m - r);
      if (sum[64]) begin
        raise(tplc_pkg::ST_OVF);
        return ALL64;
      end
      return sum[63:0];
    endfunction

    // Pad one position and fold it into the running sizes
    function logic [31:0] pad_position(int unsigned p, logic [63:0] d);
      bit in_al;
      logic [63:0] a, pad;
      in_al = p < eff_rank();
      a = align_at(p);
      pad = d;
      if (in_al) begin
        if (p < 2) pad = pad_up(d, a);
        else if (acc % a == 0) pad = d;
        else if (acc != 0 && a % acc == 0) pad = pad_up(d, a / acc);
        else raise(tplc_pkg::ST_NODED);
      end
      if (pad > ALL32) begin
        raise(tplc_pkg::ST_OVF);
        pad = ALL32;
      end
      if (p != 0) acc = mul_chk(acc, pad);
      if (p == 0) begin
        run_w = d;
        if (in_al) run_w = pad_up(run_w, a);
      end else begin
        run_h = mul_chk(run_h, d);
        if (in_al) run_h = pad_up(run_h, a);
      end
      return pad[31:0];
    endfunction

    // Note an accepted dimension word and queue its expected layout words
    function void note_dim(logic [31:0] dsz, logic outer);
      int unsigned p;
      logic [63:0] d;
      layout_t w;
      d = {32'd0, dsz};
      p = pos_cnt;
      if (p >= DIM_LIMIT_TB - 1) outer = 1;
      w = '0;
      w.position = p[3:0];
      w.padded_size = pad_position(p, d);
      w.stride_elems = run_st;
      run_st = mul_chk(run_st, d);
      if (p < eff_rank()) run_st = pad_up(run_st, align_at(p));
      w.status = err;
      if (!outer) begin
        pending.push_back(w);
        pos_cnt = p + 1;
        return;
      end
      for (int unsigned q = p + 1; q < eff_rank(); q++) begin
        pending.push_back(w);
        w = '0;
        w.position = q[3:0];
        w.padded_size = pad_position(q, 1);
        w.status = err;
      end
      w.phys_height = run_h;
      w.phys_width = run_w;
      w.status = err;
      w.final_result = 1;
      pending.push_back(w);
      clear_run();
    endfunction

    function void check_word(layout_t got);
      layout_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        fails++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, got);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  tplc_dim_if dims ();
  tplc_res_if results ();
  layout_board board;
  int idle_cycles;

  tensor_padded_layout_calc i_dut (
    .clk(clk), .rst(rst), .dims(dims.sink), .results(results.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, check every accepted word
  initial begin
    int gap;
    layout_t got;
    results.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        results.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      results.ready <= 1;
      @(posedge clk iff results.valid);
      got = '{position: results.position, padded_size: results.padded_size,
              stride_elems: results.stride_elems, phys_height: results.phys_height,
              phys_width: results.phys_width, status: results.status,
              final_result: results.final_result};
      board.check_word(got);
    end
  end

  // Watchdog: count cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (dims.valid && dims.ready) || (results.valid && results.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Let the block drain before touching registers
  task automatic wait_idle();
    dims.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Drive one dimension word; valid stays up when the next word follows at once
  task automatic send_dim(logic [31:0] dsz, logic outer);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      dims.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    dims.valid <= 1;
    dims.dim_size <= dsz;
    dims.outermost <= outer;
    @(posedge clk iff dims.ready);
    board.note_dim(dsz, outer);
  endtask

  function automatic logic [31:0] rand_align();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'd1 << $urandom_range(0, 6);
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return 32'h8000_0000 | $urandom();
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic random_cfg();
    write_cfg(tplc_pkg::CFG_ALIGN_RANK, $urandom_range(0, 7));
    for (int i = 0; i < tplc_pkg::NUM_ALIGN; i++)
      write_cfg(tplc_pkg::CFG_ALIGN_POS0 + 3'(i), rand_align());
  endtask

  initial begin
    int sent, len;
    board = new();
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    dims.valid = 0; dims.dim_size = 0; dims.outermost = 0;
    board.reset_all();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default registers, then full rank with power-of-two alignments
    send_dim(7, 1);
    send_dim(32'hFFFF_FFFF, 0); send_dim(32'hFFFF_FFFF, 0);
    send_dim(32'hFFFF_FFFF, 1);
    wait_idle();
    write_cfg(tplc_pkg::CFG_ALIGN_RANK, 6);
    for (int i = 0; i < tplc_pkg::NUM_ALIGN; i++)
      write_cfg(tplc_pkg::CFG_ALIGN_POS0 + 3'(i), 32'd1 << (i + 1));
    send_dim(3, 0); send_dim(5, 0); send_dim(1, 0); send_dim(2, 1);
    send_dim(9, 1);
    send_dim(0, 0); send_dim(0, 0); send_dim(3, 1);
    // Eight dimensions without the outermost flag: shape ends on the dimension limit
    for (int i = 0; i < DIM_LIMIT_TB; i++) send_dim(32'(i + 1), 0);
    wait_idle();
    // Non-deducible padding and overflow at the top of the alignment range
    write_cfg(tplc_pkg::CFG_ALIGN_POS2, 7);
    write_cfg(tplc_pkg::CFG_ALIGN_POS3, 32'hFFFF_FFFF);
    write_cfg(tplc_pkg::CFG_ALIGN_RANK, 7);
    send_dim(3, 0); send_dim(3, 0); send_dim(5, 0); send_dim(32'hFFFF_FFFF, 1);
    sent = 24;

    // Random shapes under a fresh setting now and then
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        random_cfg();
      end
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        send_dim(rand_dim(), (i == len - 1) || ($urandom_range(0, 15) == 0));
        sent++;
      end
    end
    dims.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
